### hw/rtl/prdf_pkg.sv
package prdf_pkg;

    localparam logic [7:0]  START_TOKEN   = 8'h01;
    localparam logic [7:0]  END_TOKEN     = 8'hFE;
    localparam logic [7:0]  NODE_ID_RESET = 8'd1;
    localparam logic [15:0] TIMEOUT_RESET = 16'd25000;

    // register indexes on the config port
    localparam int unsigned CFG_INDEX_W = 1;
    localparam logic [CFG_INDEX_W-1:0] CFG_NODE_ID = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_TIMEOUT = 1'b1;
    localparam int unsigned CFG_DATA_W  = 16;

    // result event codes
    localparam logic [2:0] EV_NONE    = 3'd0;
    localparam logic [2:0] EV_DATA    = 3'd1;
    localparam logic [2:0] EV_ACCEPT  = 3'd2;
    localparam logic [2:0] EV_REJECT  = 3'd3;
    localparam logic [2:0] EV_TIMEOUT = 3'd4;
    localparam logic [2:0] EV_DISCARD = 3'd5;

    typedef enum logic [6:0] {
        ST_WAIT    = 7'b0000001,
        ST_LEN     = 7'b0000010,
        ST_ID      = 7'b0000100,
        ST_CMD     = 7'b0001000,
        ST_PAYLOAD = 7'b0010000,
        ST_CSUM    = 7'b0100000,
        ST_END     = 7'b1000000
    } frame_step_t;

    typedef struct packed {
        frame_step_t step;
        logic [7:0]  sum;
        logic [7:0]  count;
        logic [7:0]  length;
        logic [7:0]  command;
        logic        addressed;
        logic [15:0] idle;
    } rx_state_t;

    typedef struct packed {
        logic       mode;
        logic [7:0] rx_byte;
        logic       transmitting;
    } item_t;

    typedef struct packed {
        logic [2:0] event_res;
        logic [7:0] data_byte;
        logic [7:0] data_index;
        logic [7:0] command_code;
        logic [7:0] payload_length;
    } result_t;

    // receiver restart: length and command are kept
    function automatic rx_state_t rx_restart(input rx_state_t st);
        rx_state_t r;
        r           = st;
        r.step      = ST_WAIT;
        r.sum       = '0;
        r.count     = '0;
        r.addressed = 1'b1;
        r.idle      = '0;
        return r;
    endfunction

endpackage

### hw/rtl/prdf_step.sv
module prdf_step (
    input  prdf_pkg::rx_state_t state_cur,
    input  prdf_pkg::item_t     item,
    input  logic [7:0]          node_id,
    input  logic [15:0]         timeout_ticks,
    output prdf_pkg::rx_state_t state_next,
    output prdf_pkg::result_t   res
);
    import prdf_pkg::*;

    logic [16:0] idle_inc;
    logic [7:0]  count_inc;
    logic [7:0]  b;

    assign idle_inc  = {1'b0, state_cur.idle} + 17'd1;
    assign count_inc = state_cur.count + 8'd1;
    assign b         = item.rx_byte;

    always_comb
    begin
        state_next = state_cur;
        res        = '0;
        res.event_res = EV_NONE;
        if (item.mode)
        begin
            // tick: only counts inside a packet and while not transmitting
            if (state_cur.step != ST_WAIT && !item.transmitting)
            begin
                if (idle_inc >= {1'b0, timeout_ticks})
                begin
                    state_next    = rx_restart(state_cur);
                    res.event_res = EV_TIMEOUT;
                end
                else
                begin
                    state_next.idle = idle_inc[15:0];
                end
            end
        end
        else if (item.transmitting)
        begin
            state_next    = rx_restart(state_cur);
            res.event_res = EV_DISCARD;
        end
        else
        begin
            state_next.idle = '0;
            unique case (state_cur.step)
                ST_WAIT:
                begin
                    if (b == START_TOKEN)
                    begin
                        state_next.step = ST_LEN;
                    end
                    else
                    begin
                        state_next    = rx_restart(state_cur);
                        res.event_res = EV_DISCARD;
                    end
                end
                ST_LEN:
                begin
                    state_next.length = b;
                    state_next.sum    = state_cur.sum + b;
                    state_next.step   = ST_ID;
                end
                ST_ID:
                begin
                    if (b == node_id)
                        state_next.sum = state_cur.sum + b;
                    else
                        state_next.addressed = 1'b0;
                    state_next.step = ST_CMD;
                end
                ST_CMD:
                begin
                    if (state_cur.addressed)
                    begin
                        state_next.command = b;
                        state_next.sum     = state_cur.sum + b;
                    end
                    state_next.step = (state_cur.length != 8'd0) ? ST_PAYLOAD : ST_CSUM;
                end
                ST_PAYLOAD:
                begin
                    state_next.count = count_inc;
                    if (count_inc >= state_cur.length)
                        state_next.step = ST_CSUM;
                    if (state_cur.addressed)
                    begin
                        state_next.sum = state_cur.sum + b;
                        res.event_res  = EV_DATA;
                        res.data_byte  = b;
                        res.data_index = state_cur.count;
                    end
                end
                ST_CSUM:
                begin
                    if (b != ~state_cur.sum)
                        state_next.addressed = 1'b0;
                    state_next.step = ST_END;
                end
                ST_END:
                begin
                    if (state_cur.addressed && b == END_TOKEN)
                    begin
                        res.event_res      = EV_ACCEPT;
                        res.command_code   = state_cur.command;
                        res.payload_length = state_cur.length;
                    end
                    else
                    begin
                        res.event_res = EV_REJECT;
                    end
                    state_next = rx_restart(state_next);
                end
                default:
                begin
                    state_next    = rx_restart(state_cur);
                    res.event_res = EV_DISCARD;
                end
            endcase
        end
    end

endmodule

### hw/rtl/packet_receiver_deframer.sv
// Channel   Handshake                  Payload   Notes
// item      item_valid / item_ready    item      one byte or one tick per beat
// result    result_valid / result_ready result   one result per item beat
// config    cfg_we                     cfg_index, cfg_data  0 node_id, 1 timeout_ticks
//
// One item beat per cycle; its result shows up the cycle after acceptance.
// Latency is set by the single output register behind the step logic.
// A stalled result holds the output register; item_ready drops only then.
// rst_n (async, active low) returns the frame logic to waiting for a start
// token and loads node_id 1 and timeout_ticks 25000.
module packet_receiver_deframer (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  item_valid,
    output logic                                  item_ready,
    input  prdf_pkg::item_t                       item,
    output logic                                  result_valid,
    input  logic                                  result_ready,
    output prdf_pkg::result_t                     result,
    input  logic                                  cfg_we,
    input  logic [prdf_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [prdf_pkg::CFG_DATA_W-1:0]       cfg_data
);
    import prdf_pkg::*;

    rx_state_t   state_reg;
    rx_state_t   state_next;
    result_t     result_reg;
    result_t     result_next;
    logic        result_valid_reg;
    logic [7:0]  node_id_reg;
    logic [15:0] timeout_reg;
    logic        item_fire;

    // output register frees up when it is empty or being drained
    assign item_ready   = !result_valid_reg || result_ready;
    assign item_fire    = item_valid && item_ready;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    prdf_step u_step (
        .state_cur     (state_reg),
        .item          (item),
        .node_id       (node_id_reg),
        .timeout_ticks (timeout_reg),
        .state_next    (state_next),
        .res           (result_next)
    );

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_id_reg <= NODE_ID_RESET;
            timeout_reg <= TIMEOUT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_NODE_ID: node_id_reg <= cfg_data[7:0];
                CFG_TIMEOUT: timeout_reg <= cfg_data;
                default:     ;
            endcase
        end
    end

    // frame state, updated once per accepted beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.step      <= ST_WAIT;
            state_reg.sum       <= '0;
            state_reg.count     <= '0;
            state_reg.length    <= '0;
            state_reg.command   <= '0;
            state_reg.addressed <= 1'b1;
            state_reg.idle      <= '0;
        end
        else if (item_fire)
        begin
            state_reg <= state_next;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (item_ready)
        begin
            result_valid_reg <= item_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_fire)
            result_reg <= result_next;
    end

    // an accepted beat always lands in the output register
    a_fire_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        item_fire |=> result_valid)
        else $error("accepted beat produced no result");

    // input stalls only behind a waiting result
    a_stall_only_on_full: assert property (@(posedge clk) disable iff (!rst_n)
        !item_ready |-> result_valid_reg)
        else $error("input stalled with empty output register");

    // no idle count while waiting for a start token
    a_idle_clear_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.step == ST_WAIT) |-> (state_reg.idle == 16'd0))
        else $error("idle counter running outside a packet");

    // data fields only on payload events
    a_data_only_on_payload: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.event_res != EV_DATA)
            |-> (result.data_byte == 8'd0 && result.data_index == 8'd0))
        else $error("data fields set on non-payload result");

    // a new frame always starts from an empty checksum
    a_sum_clear_after_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.step == ST_LEN) |-> (state_reg.sum == 8'd0 && state_reg.addressed))
        else $error("frame started with stale checksum state");

endmodule

### tb/packet_receiver_deframer_test.sv
`timescale 1ns / 1ps

module packet_receiver_deframer_test;

    import prdf_pkg::*;

    // beat kinds on the item channel
    localparam logic MODE_BYTE = 1'b0;
    localparam logic MODE_TICK = 1'b1;

    // no-progress limit: covers the long sink hold plus long gaps, several times over
    localparam int STALL_LIMIT  = 3000;
    localparam int SINK_HOLD    = 300;
    localparam int PHASE_BYTES  = 150;
    localparam int PHASE_COUNT  = 5;

    logic                   clk;
    logic                   rst_n;
    logic                   item_valid;
    logic                   item_ready;
    item_t                  item;
    logic                   result_valid;
    logic                   result_ready;
    result_t                result;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    packet_receiver_deframer DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // 2 ns period
    initial clk = 1'b0;
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Deframer prediction: own copy of receiver state and registers
    // ------------------------------------------------------------------
    frame_step_t rx_step;
    logic [7:0]  rx_sum;
    logic [7:0]  rx_count;
    logic [7:0]  rx_len;
    logic [7:0]  rx_cmd;
    logic        rx_addr_ok;
    logic [15:0] rx_idle;
    logic [7:0]  node_addr;
    logic [15:0] tick_limit;

    result_t expected_results[$];

    // length and command survive a restart
    function automatic void restart_rx();
        rx_step    = ST_WAIT;
        rx_sum     = '0;
        rx_count   = '0;
        rx_addr_ok = 1'b1;
        rx_idle    = '0;
    endfunction

    function automatic result_t deframe_step(input item_t it);
        result_t     r;
        logic [16:0] next_idle;
        logic [7:0]  b;
        r = '0;
        b = it.rx_byte;
        if (it.mode == MODE_TICK)
        begin
            // ticks only count inside a packet and with the bus free
            if (rx_step != ST_WAIT && !it.transmitting)
            begin
                next_idle = {1'b0, rx_idle} + 17'd1;
                // a limit of 0 trips on the first tick, same as 1
                if (next_idle >= {1'b0, tick_limit})
                begin
                    restart_rx();
                    r.event_res = EV_TIMEOUT;
                end
                else
                    rx_idle = next_idle[15:0];
            end
            return r;
        end
        // our own transmission echoing back: drop everything
        if (it.transmitting)
        begin
            restart_rx();
            r.event_res = EV_DISCARD;
            return r;
        end
        rx_idle = '0;
        case (rx_step)
            ST_WAIT:
                if (b == START_TOKEN)
                    rx_step = ST_LEN;
                else
                begin
                    restart_rx();
                    r.event_res = EV_DISCARD;
                end
            ST_LEN:
            begin
                rx_len  = b;
                rx_sum  = rx_sum + b;
                rx_step = ST_ID;
            end
            ST_ID:
            begin
                // foreign packets are still tracked to the end token
                if (b == node_addr)
                    rx_sum = rx_sum + b;
                else
                    rx_addr_ok = 1'b0;
                rx_step = ST_CMD;
            end
            ST_CMD:
            begin
                if (rx_addr_ok)
                begin
                    rx_cmd = b;
                    rx_sum = rx_sum + b;
                end
                rx_step = (rx_len != 8'd0) ? ST_PAYLOAD : ST_CSUM;
            end
            ST_PAYLOAD:
            begin
                if (rx_addr_ok)
                begin
                    rx_sum       = rx_sum + b;
                    r.event_res  = EV_DATA;
                    r.data_byte  = b;
                    r.data_index = rx_count;
                end
                rx_count = rx_count + 8'd1;
                if (rx_count >= rx_len)
                    rx_step = ST_CSUM;
            end
            ST_CSUM:
            begin
                if (b != ~rx_sum)
                    rx_addr_ok = 1'b0;
                rx_step = ST_END;
            end
            ST_END:
            begin
                if (rx_addr_ok && b == END_TOKEN)
                begin
                    r.event_res      = EV_ACCEPT;
                    r.command_code   = rx_cmd;
                    r.payload_length = rx_len;
                end
                else
                    r.event_res = EV_REJECT;
                restart_rx();
            end
            default:
            begin
                restart_rx();
                r.event_res = EV_DISCARD;
            end
        endcase
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Handshake pacing
    // ------------------------------------------------------------------
    bit src_idles;
    bit sink_idles;
    int sink_hold;

    // mostly short, now and then long
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 2);
        else if (r < 95)
            return $urandom_range(3, 6);
        else
            return $urandom_range(15, 40);
    endfunction

    // sink: runs of ready and stalls, plus a one-off long hold requested by the stimulus
    initial
    begin : sink_pacing
        int stall_left;
        int run_left;
        stall_left   = 0;
        run_left     = 0;
        result_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (sink_hold > 0)
            begin
                stall_left = sink_hold;
                run_left   = 0;
                sink_hold  = 0;
            end
            if (stall_left == 0 && run_left == 0)
            begin
                if (!sink_idles || $urandom_range(0, 1) == 1)
                    run_left = $urandom_range(1, 16);
                else
                    stall_left = idle_len();
            end
            if (stall_left > 0)
            begin
                result_ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                result_ready <= 1'b1;
                run_left--;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result checking and watchdog
    // ------------------------------------------------------------------
    int errors;
    int stuck;
    int n_accept, n_reject, n_timeout, n_discard, n_data;

    task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (got !== want)
        begin
            errors++;
            if (errors <= 30)
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        end
    endtask

    always @(posedge clk)
    begin : result_check
        result_t want;
        if (rst_n)
        begin
            if ((item_valid && item_ready) || (result_valid && result_ready))
                stuck = 0;
            else
            begin
                stuck++;
                if (stuck >= STALL_LIMIT)
                begin
                    $display("%0t: no beat moved for %0d cycles", $time, STALL_LIMIT);
                    $display("Some tests failed");
                    $finish;
                end
            end
            if (result_valid && result_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    errors++;
                    if (errors <= 30)
                        $display("%0t: unexpected result, expected none, actual %0h",
                                 $time, result);
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("event_res",      {5'b0, want.event_res},
                                {5'b0, result.event_res});
                    check_field("data_byte",      want.data_byte,      result.data_byte);
                    check_field("data_index",     want.data_index,     result.data_index);
                    check_field("command_code",   want.command_code,   result.command_code);
                    check_field("payload_length", want.payload_length, result.payload_length);
                    case (want.event_res)
                        EV_ACCEPT:  n_accept++;
                        EV_REJECT:  n_reject++;
                        EV_TIMEOUT: n_timeout++;
                        EV_DISCARD: n_discard++;
                        EV_DATA:    n_data++;
                        default:    ;
                    endcase
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    int beats_in;
    int bytes_sent;

    // one item beat; the expectation is queued at the accepting edge
    task automatic send_beat(input item_t it, input bit pinned = 1'b0,
                             input result_t pin = '0);
        int      gap;
        result_t predicted;
        gap = (src_idles && $urandom_range(0, 9) < 4) ? idle_len() : 0;
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item       <= it;
        item_valid <= 1'b1;
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
        predicted = deframe_step(it);
        expected_results.push_back(pinned ? pin : predicted);
        beats_in++;
    endtask

    // a bus byte, sometimes preceded by a burst of ticks (timeouts with small limits)
    task automatic put_byte(input logic [7:0] b);
        item_t it;
        if ($urandom_range(0, 9) == 0)
        begin
            repeat ($urandom_range(1, 12))
            begin
                it.mode         = MODE_TICK;
                it.rx_byte      = 8'($urandom);
                it.transmitting = ($urandom_range(0, 7) == 0);
                send_beat(it);
            end
        end
        it.mode         = MODE_BYTE;
        it.rx_byte      = b;
        it.transmitting = ($urandom_range(0, 199) == 0);
        send_beat(it);
        bytes_sent++;
    endtask

    // well-formed frame with random content; sometimes foreign id, bad checksum, bad end or cut short
    task automatic send_packet();
        logic [7:0] frame[$];
        logic [7:0] len;
        logic [7:0] id;
        logic [7:0] cmd;
        logic [7:0] sum;
        logic [7:0] b;
        int         r;
        int         n;
        r = $urandom_range(0, 199);
        if (r == 0)
            len = 8'd255;
        else if (r < 6)
            len = 8'($urandom_range(9, 254));
        else
            len = 8'($urandom_range(0, 8));
        id  = ($urandom_range(0, 99) < 85) ? node_addr : 8'($urandom);
        cmd = 8'($urandom);
        frame = {START_TOKEN, len, id, cmd};
        sum = len + id + cmd;
        for (int i = 0; i < len; i++)
        begin
            b = 8'($urandom);
            frame.push_back(b);
            sum = sum + b;
        end
        frame.push_back(($urandom_range(0, 9) != 0) ? ~sum : 8'($urandom));
        frame.push_back(($urandom_range(0, 19) != 0) ? END_TOKEN : 8'($urandom));
        n = frame.size();
        if ($urandom_range(0, 99) < 8)
            n = $urandom_range(1, n - 1);
        for (int i = 0; i < n; i++)
            put_byte(frame[i]);
    endtask

    // stray bytes, ticks and echoes of our own transmission
    task automatic send_noise();
        item_t it;
        repeat ($urandom_range(1, 4))
        begin
            it.mode         = ($urandom_range(0, 3) == 0) ? MODE_TICK : MODE_BYTE;
            it.rx_byte      = ($urandom_range(0, 3) == 0) ? START_TOKEN : 8'($urandom);
            it.transmitting = ($urandom_range(0, 3) == 0);
            send_beat(it);
            if (it.mode == MODE_BYTE)
                bytes_sent++;
        end
    endtask

    // drain: lower valid at the last accepting edge, wait out the results plus latency
    task automatic wait_idle();
        item_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_config(input logic [7:0] nid, input logic [15:0] tmo);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_NODE_ID;
        cfg_data  <= {8'h00, nid};
        @(posedge clk);
        cfg_index <= CFG_TIMEOUT;
        cfg_data  <= tmo;
        @(posedge clk);
        cfg_we    <= 1'b0;
        node_addr  = nid;
        tick_limit = tmo;
    endtask

    // directed rows: pinned ones carry a hand-written expectation
    typedef struct packed {
        item_t   beat;
        bit      pinned;
        result_t want;
    } dir_row_t;

    function automatic dir_row_t row(input logic mode, input logic [7:0] b, input logic tx,
                                     input bit pinned = 1'b0, input logic [2:0] ev = EV_NONE,
                                     input logic [7:0] db = 8'h00, input logic [7:0] di = 8'h00,
                                     input logic [7:0] cc = 8'h00, input logic [7:0] pl = 8'h00);
        dir_row_t d;
        d.beat.mode         = mode;
        d.beat.rx_byte      = b;
        d.beat.transmitting = tx;
        d.pinned            = pinned;
        d.want.event_res    = ev;
        d.want.data_byte    = db;
        d.want.data_index   = di;
        d.want.command_code = cc;
        d.want.payload_length = pl;
        return d;
    endfunction

    initial
    begin : stimulus
        dir_row_t   dir_rows[25];
        logic [7:0]  nid;
        logic [15:0] tmo;

        rst_n      = 1'b0;
        item_valid = 1'b0;
        item       = '0;
        cfg_we     = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        src_idles  = 1'b1;
        sink_idles = 1'b1;
        sink_hold  = 0;
        errors     = 0;
        stuck      = 0;
        beats_in   = 0;
        node_addr  = NODE_ID_RESET;
        tick_limit = TIMEOUT_RESET;
        rx_len     = '0;
        rx_cmd     = '0;
        restart_rx();

        // runs on reset register values (node 1)
        dir_rows = '{
            row(MODE_BYTE, 8'h00,       1'b0, 1'b1, EV_DISCARD),     // stray byte while waiting
            row(MODE_TICK, 8'h00,       1'b0, 1'b1, EV_NONE),        // tick while waiting
            row(MODE_BYTE, START_TOKEN, 1'b1, 1'b1, EV_DISCARD),     // byte while transmitting
            row(MODE_BYTE, START_TOKEN, 1'b0, 1'b1, EV_NONE),
            row(MODE_BYTE, 8'h02,       1'b0),                       // length
            row(MODE_TICK, 8'h00,       1'b0),                       // tick inside a packet
            row(MODE_TICK, 8'hFF,       1'b1),                       // tick while transmitting
            row(MODE_BYTE, 8'h01,       1'b0),                       // our id
            row(MODE_BYTE, 8'hFF,       1'b0),                       // command
            row(MODE_BYTE, 8'h00,       1'b0, 1'b1, EV_DATA, 8'h00, 8'h00),
            row(MODE_BYTE, 8'hFF,       1'b0, 1'b1, EV_DATA, 8'hFF, 8'h01),
            row(MODE_BYTE, 8'hFE,       1'b0),                       // checksum
            row(MODE_BYTE, END_TOKEN,   1'b0, 1'b1, EV_ACCEPT, 8'h00, 8'h00, 8'hFF, 8'h02),
            // zero length, foreign id
            row(MODE_BYTE, START_TOKEN, 1'b0),
            row(MODE_BYTE, 8'h00,       1'b0),
            row(MODE_BYTE, 8'h55,       1'b0),
            row(MODE_BYTE, 8'h80,       1'b0),
            row(MODE_BYTE, 8'h7E,       1'b0),
            row(MODE_BYTE, END_TOKEN,   1'b0, 1'b1, EV_REJECT),
            // zero length, ours, bad checksum
            row(MODE_BYTE, START_TOKEN, 1'b0),
            row(MODE_BYTE, 8'h00,       1'b0),
            row(MODE_BYTE, 8'h01,       1'b0),
            row(MODE_BYTE, 8'h80,       1'b0),
            row(MODE_BYTE, 8'h00,       1'b0),
            row(MODE_BYTE, END_TOKEN,   1'b0, 1'b1, EV_REJECT)
        };

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
            send_beat(dir_rows[i].beat, dir_rows[i].pinned, dir_rows[i].want);

        // random phases, each on its own register setting
        for (int p = 0; p < PHASE_COUNT; p++)
        begin
            wait_idle();
            case (p)
                0:       begin nid = 8'h00;         tmo = 16'd1;                      end
                1:       begin nid = 8'hFF;         tmo = 16'hFFFF;                   end
                2:       begin nid = 8'($urandom);  tmo = 16'd0;                      end
                3:       begin nid = 8'($urandom);  tmo = 16'($urandom_range(2, 16)); end
                default: begin nid = NODE_ID_RESET; tmo = 16'd6;                      end
            endcase
            write_config(nid, tmo);
            // one phase runs flat out on both sides
            src_idles  = (p != 1);
            sink_idles = (p != 1);
            // long sink hold while items keep coming: the block must back up
            if (p == 2)
                sink_hold = SINK_HOLD;
            bytes_sent = 0;
            while (bytes_sent < PHASE_BYTES)
            begin
                if ($urandom_range(0, 3) != 0)
                    send_packet();
                else
                    send_noise();
            end
        end

        wait_idle();
        $display("Sent %0d item beats over %0d register settings plus reset values.",
                 beats_in, PHASE_COUNT);
        $display("Seen: %0d accepted, %0d rejected, %0d timeouts, %0d discards, %0d payload bytes.",
                 n_accept, n_reject, n_timeout, n_discard, n_data);
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
